// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the jitter buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define AJB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define AJB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ajb_pkg.sv =====
// Package of the audio jitter buffer: codes, register types and result metadata.
package ajb_pkg;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [15:0] TARGET_RESET = 16'd7680;
  localparam logic [15:0] MAX_RESET    = 16'd24000;
  localparam logic [15:0] GAIN_RESET   = 16'd32768;

  localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
  localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

  localparam logic [7:0] FLOAT_EXP_BIAS = 8'd112;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } ajb_cmd_t;

  typedef enum logic [1:0] {
    FMT_S16 = 2'd0,
    FMT_S32 = 2'd1,
    FMT_F32 = 2'd2
  } ajb_fmt_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET = 4'd0,
    REG_MAX    = 4'd1,
    REG_GAIN   = 4'd2,
    REG_FORMAT = 4'd3
  } ajb_reg_t;

  typedef struct packed {
    logic [15:0] target_depth;
    logic [15:0] max_depth;
    logic [15:0] gain_q15;
    logic [1:0]  out_format;
  } ajb_cfg_t;

  typedef struct packed {
    logic        got;
    logic        buffering;
    logic [15:0] fill_level;
    logic [31:0] rebuffers;
    logic [31:0] dropped;
  } ajb_meta_t;

endpackage

// ===== rtl/ajb_ring.sv =====
// Sample ring memory: one write port and one read port with registered read data.
module ajb_ring #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled result keeps its sample.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ajb_fmt.sv =====
// Output formatter: raw 16-bit, left-aligned 32-bit or float32 bit pattern.
module ajb_fmt (
  input  logic        got,
  input  logic [1:0]  out_format,
  input  logic [15:0] sample,
  output logic [31:0] word
);

  logic        neg;
  logic [16:0] neg_val;
  logic [15:0] mag;
  logic [4:0]  msb;
  logic [23:0] mant_full;
  logic [7:0]  expo;
  logic [31:0] fbits;

  always_comb begin
    neg       = sample[15];
    neg_val   = 17'd0 - {1'b0, sample};
    mag       = neg ? neg_val[15:0] : sample;
    msb       = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) begin
        msb = 5'(i);
      end
    end
    expo      = {3'd0, msb} + ajb_pkg::FLOAT_EXP_BIAS;
    mant_full = {8'd0, mag} << (5'd23 - msb);
    fbits     = (mag == 16'd0) ? 32'd0 : {neg, expo, mant_full[22:0]};
  end

  always_comb begin
    if (!got) begin
      word = 32'd0;
    end else begin
      unique case (out_format)
        ajb_pkg::FMT_S32: word = {sample, 16'd0};
        ajb_pkg::FMT_F32: word = fbits;
        default:          word = {16'd0, sample};
      endcase
    end
  end

endmodule

// ===== rtl/ajb_ctrl.sv =====
// Ring control: pointers, fill, cushion policy, counters and the ring access of each item.
module ajb_ctrl #(
  parameter int unsigned RING_DEPTH = 32768,
  parameter int unsigned PW         = 15,
  parameter int unsigned FW         = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ajb_pkg::ajb_cfg_t   cfg,
  input  logic                item_valid,
  input  ajb_pkg::ajb_cmd_t   cmd,
  input  logic                burst_first,
  input  logic [15:0]         burst_len,
  input  logic signed [15:0]  sample_in,
  output logic                wr_en,
  output logic [PW-1:0]       wr_addr,
  output logic [15:0]         wr_data,
  output logic                rd_en,
  output logic [PW-1:0]       rd_addr,
  output logic                meta_valid,
  output ajb_pkg::ajb_meta_t  meta
);

  // Wide enough for the fill plus a burst length.
  localparam int unsigned TW = ((FW > 16) ? FW : 16) + 1;

  logic [PW-1:0] read_ptr_r, read_ptr_nxt;
  logic [PW-1:0] write_ptr_r, write_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          buffering_r, buffering_nxt;
  logic [31:0]   rebuffers_r, rebuffers_nxt;
  logic [31:0]   dropped_r, dropped_nxt;

  logic [TW-1:0] fill_t, blen_t, tgt_t, max_t, total, keep_raw, keep, push_drop, drop;
  logic [TW-1:0] fill_out_t;
  logic [FW-1:0] drop_f, fill_1;
  logic [FW:0]   rp_sum;
  logic [PW-1:0] rp_1;
  logic          pull_start, buf_1;
  logic          got;

  logic signed [32:0] prod, biased;
  logic signed [17:0] quot;
  logic signed [17:0] sat;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Gain scaling, truncating toward zero, then saturation to 16 bits.
  always_comb begin
    prod   = 33'(sample_in) * $signed({17'd0, cfg.gain_q15});
    biased = prod[32] ? prod + 33'sd32767 : prod;
    quot   = 18'(biased >>> 15);
    if (quot > ajb_pkg::SAMPLE_MAX) begin
      sat = ajb_pkg::SAMPLE_MAX;
    end else if (quot < ajb_pkg::SAMPLE_MIN) begin
      sat = ajb_pkg::SAMPLE_MIN;
    end else begin
      sat = quot;
    end
  end

  always_comb begin
    fill_t   = TW'(fill_r);
    blen_t   = TW'(burst_len);
    tgt_t    = TW'(cfg.target_depth);
    max_t    = TW'(cfg.max_depth);
    total    = fill_t + blen_t;
    keep_raw = (max_t > blen_t) ? max_t : blen_t;
    keep     = (keep_raw > TW'(RING_DEPTH)) ? TW'(RING_DEPTH) : keep_raw;

    // Push burst check: skip back to target, or the whole fill on a shortfall.
    push_drop = '0;
    if (burst_first && (burst_len != 16'd0) && (total > keep)) begin
      push_drop = (total > tgt_t) ? total - tgt_t : fill_t;
      if (push_drop > fill_t) begin
        push_drop = fill_t;
      end
    end

    pull_start = burst_first && buffering_r && (fill_t >= tgt_t);

    if (cmd == ajb_pkg::CMD_PUSH) begin
      drop = push_drop;
    end else begin
      drop = pull_start ? fill_t - tgt_t : '0;
    end
    drop_f = drop[FW-1:0];

    rp_sum = {1'b0, read_ptr_r} + {1'b0, drop_f};
    if (rp_sum >= (FW+1)'(RING_DEPTH)) begin
      rp_sum = rp_sum - (FW+1)'(RING_DEPTH);
    end
    rp_1   = rp_sum[PW-1:0];
    fill_1 = fill_r - drop_f;
    buf_1  = (cmd == ajb_pkg::CMD_PULL && pull_start) ? 1'b0 : buffering_r;

    read_ptr_nxt  = rp_1;
    write_ptr_nxt = write_ptr_r;
    fill_nxt      = fill_1;
    buffering_nxt = buf_1;
    rebuffers_nxt = rebuffers_r;
    dropped_nxt   = dropped_r + 32'(drop_f);
    got           = 1'b0;

    if (cmd == ajb_pkg::CMD_PUSH) begin
      write_ptr_nxt = ptr_inc(write_ptr_r);
      if (fill_1 < FW'(RING_DEPTH)) begin
        fill_nxt = fill_1 + FW'(1);
      end else begin
        read_ptr_nxt = ptr_inc(rp_1);
      end
    end else if (!buf_1) begin
      if (fill_1 != '0) begin
        got          = 1'b1;
        read_ptr_nxt = ptr_inc(rp_1);
        fill_nxt     = fill_1 - FW'(1);
      end else begin
        buffering_nxt = 1'b1;
        rebuffers_nxt = rebuffers_r + 32'd1;
      end
    end

    fill_out_t = TW'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_ptr_r  <= '0;
      write_ptr_r <= '0;
      fill_r      <= '0;
      buffering_r <= 1'b1;
      rebuffers_r <= '0;
      dropped_r   <= '0;
    end else if (item_valid) begin
      read_ptr_r  <= read_ptr_nxt;
      write_ptr_r <= write_ptr_nxt;
      fill_r      <= fill_nxt;
      buffering_r <= buffering_nxt;
      rebuffers_r <= rebuffers_nxt;
      dropped_r   <= dropped_nxt;
    end
  end

  assign wr_en   = item_valid && (cmd == ajb_pkg::CMD_PUSH);
  assign wr_addr = write_ptr_r;
  assign wr_data = sat[15:0];
  assign rd_en   = item_valid && got;
  assign rd_addr = rp_1;

  assign meta_valid      = item_valid && (cmd == ajb_pkg::CMD_PULL);
  assign meta.got        = got;
  assign meta.buffering  = buffering_nxt;
  assign meta.fill_level = fill_out_t[15:0];
  assign meta.rebuffers  = rebuffers_nxt;
  assign meta.dropped    = dropped_nxt;

endmodule

// ===== rtl/audio_jitter_buffer.sv =====
// Top level of the audio jitter buffer: ring FIFO of 16-bit PCM with a cushion policy.
//
// The block takes one item per clock cycle, push or pull, for as long as the result side
// keeps taking results. A pull reads the ring at the edge that accepts it, while its
// metadata enters the read stage; the formatted result then moves into the output
// register once that register is empty or its result is taken. The single ring memory
// has one write port used by pushes and one registered read port used by pulls. Pushes
// give no result. Every pull gives exactly one result, from the ring or padded silence.
// While the output register holds a result that is not taken and a second pull waits in
// the read stage, the input stalls. The ring needs no clearing after reset: a sample is
// read only after it was written. The user must write the configuration registers
// through the cfg_ port only while no item is in flight; the block does not enforce it.
module audio_jitter_buffer #(
  parameter int unsigned RING_DEPTH = 32768
) (
  input  logic          clk,
  input  logic          rst_n,
  // Input items.
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // burst_len[15:0], sample_in[31:16]
  input  logic [1:0]    in_tuser,   // cmd[0], burst_first[1]
  // Result items.
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // sample_word[31:0], fill_level[47:32],
                                    // rebuffer_count[79:48], dropped_count[111:80]
  output logic [1:0]    out_tuser,  // from_ring[0], is_buffering[1]
  // Configuration writes.
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [ajb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ajb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);

  // Configuration registers; the port never stalls.
  ajb_pkg::ajb_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_depth <= ajb_pkg::TARGET_RESET;
      cfg_r.max_depth    <= ajb_pkg::MAX_RESET;
      cfg_r.gain_q15     <= ajb_pkg::GAIN_RESET;
      cfg_r.out_format   <= ajb_pkg::FMT_S16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ajb_pkg::REG_TARGET: cfg_r.target_depth <= cfg_data;
        ajb_pkg::REG_MAX:    cfg_r.max_depth    <= cfg_data;
        ajb_pkg::REG_GAIN:   cfg_r.gain_q15     <= cfg_data;
        ajb_pkg::REG_FORMAT: cfg_r.out_format   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline: the read stage holds the metadata of a pull while the ring is read,
  // the output register holds the finished result until it is taken.
  logic               s1_valid_r, s1_valid_nxt;
  ajb_pkg::ajb_meta_t s1_meta_r;
  logic               s1_adv;
  logic               out_valid_r, out_valid_nxt;
  logic [111:0]       out_data_r;
  logic [1:0]         out_user_r;

  logic               in_accept;
  logic               wr_en, rd_en, meta_valid;
  logic [PW-1:0]      wr_addr, rd_addr;
  logic [15:0]        wr_data, rd_data;
  ajb_pkg::ajb_meta_t meta;
  logic [31:0]        sample_word;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  ajb_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .PW         (PW),
    .FW         (FW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_valid  (in_accept),
    .cmd         (ajb_pkg::ajb_cmd_t'(in_tuser[0])),
    .burst_first (in_tuser[1]),
    .burst_len   (in_tdata[15:0]),
    .sample_in   ($signed(in_tdata[31:16])),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .meta_valid  (meta_valid),
    .meta        (meta)
  );

  ajb_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (PW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ajb_fmt u_fmt (
    .got        (s1_meta_r.got),
    .out_format (cfg_r.out_format),
    .sample     (rd_data),
    .word       (sample_word)
  );

  always_comb begin
    if (meta_valid) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_valid) begin
      s1_meta_r <= meta;
    end
    if (s1_adv) begin
      out_data_r <= {s1_meta_r.dropped, s1_meta_r.rebuffers, s1_meta_r.fill_level,
                     sample_word};
      out_user_r <= {s1_meta_r.buffering, s1_meta_r.got};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/ajb_checker.sv =====
// Port-level assertions of the audio jitter buffer and the bind that attaches them.
`include "assert_macros.svh"

module ajb_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // A result that waits must keep its contents.
  `AJB_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A sample taken from the ring means playback is running.
  `AJB_ASSERT(a_ring_not_buffering, clk, rst_n, out_tvalid && out_tuser[0] |-> !out_tuser[1], "ring sample while buffering")

  // Padded results carry silence.
  `AJB_ASSERT(a_pad_silent, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata[31:0] == 32'd0, "padded result not silent")

  // No result is shown in the cycle after reset.
  `AJB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind audio_jitter_buffer ajb_checker u_ajb_checker (.*);
